// File: rtl/isr_pkg.sv
// shared types and constants for the integer square root block
`default_nettype none

package isr_pkg;

	// field widths
	localparam int RAD_W  = 32;
	localparam int ROOT_W = 16;
	// partial remainder never exceeds twice the partial root
	localparam int REM_W  = ROOT_W + 2;
	// one cell per root bit
	localparam int STEPS  = RAD_W / 2;

	// data handed from one cell to the next
	typedef struct packed {
		logic              valid;
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] acc;
	} cell_data_t;

endpackage

`default_nettype wire

// File: rtl/isr_if.sv
// stream interfaces for radicand requests and root responses
`default_nettype none

interface isr_radicand_if;
	logic                      valid;
	logic                      ready;
	logic [isr_pkg::RAD_W-1:0] radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

interface isr_root_if;
	logic                       valid;
	logic                       ready;
	logic [isr_pkg::ROOT_W-1:0] root;

	modport source (output valid, output root, input ready);
	modport sink   (input valid, input root, output ready);
endinterface

`default_nettype wire

// File: rtl/isr_cell.sv
// one digit-by-digit square root cell: brings down two bits, decides one root bit
`default_nettype none

module isr_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire isr_pkg::cell_data_t prev,
	output isr_pkg::cell_data_t      next_q
);

	localparam int SH_W = isr_pkg::REM_W + 2;

	logic [SH_W-1:0]           rem_sh;
	logic [SH_W-1:0]           trial;
	logic [SH_W-1:0]           diff;
	logic                      fits;
	logic [isr_pkg::REM_W-1:0] rem_nx;

	// shift in the next two radicand bits and try the odd trial value
	always_comb begin
		rem_sh = {prev.rem, prev.rad[isr_pkg::RAD_W-1 -: 2]};
		trial  = {2'b00, prev.acc, 2'b01};
		diff   = rem_sh - trial;
		fits   = (rem_sh >= trial);
		rem_nx = fits ? diff[isr_pkg::REM_W-1:0] : rem_sh[isr_pkg::REM_W-1:0];
	end

	// valid flag and payload handed to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
		end else if (en) begin
			next_q.valid <= prev.valid;
			next_q.rad   <= {prev.rad[isr_pkg::RAD_W-3:0], 2'b00};
			next_q.rem   <= rem_nx;
			next_q.acc   <= {prev.acc[isr_pkg::ROOT_W-2:0], fits};
		end
	end

endmodule

`default_nettype wire

// File: rtl/integer_square_root.sv
// Integer square root: returns floor(sqrt(radicand)) of a 32-bit unsigned radicand as a
// 16-bit root, exact over the whole range. A row of sixteen identical cells computes it
// digit by digit, each cell bringing down two radicand bits and settling one root bit, and
// hands its partial remainder and root to the next cell every cycle the row advances.
// A transaction is accepted whenever the response is not held back, one new radicand per
// cycle; the result reaches the last cell after all sixteen cells. While the response
// waits, the whole row holds and no request is taken. Nothing is kept between transactions.
`default_nettype none

module integer_square_root (
	input  wire logic   clk,
	input  wire logic   arst_n,
	isr_radicand_if.sink req,
	isr_root_if.source   rsp
);

	localparam int STEPS = isr_pkg::STEPS;

	isr_pkg::cell_data_t       chain [STEPS+1];
	logic                      en;
	logic [STEPS-1:0]          valid_vec;

	// the row advances unless the last cell holds a result not yet taken
	assign en        = !chain[STEPS].valid || rsp.ready;
	assign req.ready = en;

	// head of the row
	assign chain[0].valid = req.valid;
	assign chain[0].rad   = req.radicand;
	assign chain[0].rem   = '0;
	assign chain[0].acc   = '0;

	// row of cells
	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		isr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.prev   (chain[i]),
			.next_q (chain[i+1])
		);
		assign valid_vec[i] = chain[i+1].valid;
	end

	// response from the last cell
	assign rsp.valid = chain[STEPS].valid;
	assign rsp.root  = chain[STEPS].acc;

`ifndef NO_ASSERTIONS
	// a waiting response blocks new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("request accepted while response stalled");

	// final remainder bound means the root is the floor root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ({1'b0, chain[STEPS].rem} <= {2'b00, rsp.root, 1'b0}))
		else $error("remainder exceeds twice the root");

	// a held row keeps its occupancy
	a_hold_row: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_vec))
		else $error("cell occupancy changed during stall");
`endif

endmodule

`default_nettype wire

// File: tb/integer_square_root_test.sv
// self-checking testbench for the integer square root block
`default_nettype none

module integer_square_root_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [isr_pkg::RAD_W-1:0]  radicand_t;
	typedef logic [isr_pkg::ROOT_W-1:0] root_t;

	// one outstanding root, kept with its radicand for reporting
	typedef struct {
		radicand_t radicand;
		root_t     root;
	} pending_root_t;

	logic clk;
	logic arst_n;

	isr_radicand_if req_ch ();
	isr_root_if     rsp_ch ();

	integer_square_root dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	radicand_t     radicand_queue[$];
	pending_root_t expected_roots[$];

	int unsigned fail_count;
	int unsigned src_wait;
	int unsigned snk_wait;
	bit          src_quiet;
	bit          snk_quiet;
	logic        req_taken;
	logic        rsp_taken;

	// 100 MHz clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// floor of the square root, two radicand bits brought down per step
	function automatic root_t floor_root(input radicand_t value);
		logic [33:0] remainder;
		logic [33:0] trial;
		root_t       partial;
		remainder = '0;
		partial   = '0;
		for (int i = isr_pkg::STEPS - 1; i >= 0; i--) begin
			remainder = {remainder[31:0], value[2*i +: 2]};
			trial     = {16'b0, partial, 2'b01};
			partial   = partial << 1;
			if (remainder >= trial) begin
				remainder = remainder - trial;
				partial[0] = 1'b1;
			end
		end
		return partial;
	endfunction

	// idle cycles before the next transaction, with occasional runs of none at all
	function automatic int unsigned draw_wait(inout bit quiet);
		if ($urandom_range(0, 47) == 0)
			quiet = !quiet;
		return quiet ? 0 : $urandom_range(0, 18);
	endfunction

	// random radicand from one of several shapes
	function automatic radicand_t random_radicand();
		root_t     base;
		radicand_t sq;
		base = root_t'($urandom_range(0, 16'hFFFF));
		sq   = radicand_t'(base) * radicand_t'(base);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return sq;
			2: return sq - radicand_t'($urandom_range(0, 1));
			3: return sq + radicand_t'($urandom_range(1, 2 * base));
			4: return $urandom >> $urandom_range(0, 31);
			default: begin
				// neighbourhood of the top of the range
				if ($urandom_range(0, 1))
					return 32'hFFFE0000 + radicand_t'($urandom_range(0, 32'h1FFFF));
				else
					return 32'hFFFE0000 - radicand_t'($urandom_range(1, 32'h1FFFF));
			end
		endcase
	endfunction

	// request driver, inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken || !req_ch.valid) begin
				if (req_taken)
					src_wait = draw_wait(src_quiet);
				if (src_wait > 0) begin
					req_ch.valid <= 1'b0;
					src_wait--;
				end else if (radicand_queue.size() > 0) begin
					req_ch.valid    <= 1'b1;
					req_ch.radicand <= radicand_queue.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response back-pressure, one stall drawn per transaction
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_taken)
				snk_wait = draw_wait(snk_quiet);
			if (snk_wait > 0) begin
				rsp_ch.ready <= 1'b0;
				snk_wait--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// monitor: predict on accepted requests, check accepted responses
	always @(posedge clk) begin
		req_taken <= req_ch.valid && req_ch.ready;
		rsp_taken <= rsp_ch.valid && rsp_ch.ready;
		if (req_ch.valid && req_ch.ready)
			expected_roots.push_back('{req_ch.radicand, floor_root(req_ch.radicand)});
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_roots.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected root transaction: root=%h", rsp_ch.root);
			end else begin
				if (rsp_ch.root !== expected_roots[0].root) begin
					fail_count++;
					if (fail_count <= 10)
						$display("root mismatch: radicand=%h expected=%h actual=%h",
							expected_roots[0].radicand, expected_roots[0].root, rsp_ch.root);
				end
				void'(expected_roots.pop_front());
			end
		end
	end

	// stimulus and end of run
	initial begin
		radicand_t directed[$];
		fail_count      = 0;
		src_wait        = 0;
		snk_wait        = 0;
		src_quiet       = 1'b0;
		snk_quiet       = 1'b0;
		req_taken       = 1'b0;
		rsp_taken       = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.radicand = '0;
		rsp_ch.ready    = 1'b0;
		arst_n          = 1'b0;

		// extremes, small squares and their neighbours, the top of the range and bit patterns
		directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd9, 32'd15,
			32'd16, 32'd65535, 32'd65536, 32'hFFFFFFFF, 32'hFFFE0000, 32'hFFFDFFFF,
			32'hFFFE0001, 32'hFFFF0000, 32'hAAAAAAAA, 32'h55555555, 32'h80000000,
			32'h7FFFFFFF, 32'h40000000, 32'h3FFFFFFF, 32'hFFFC0004, 32'hFFFC0003};
		foreach (directed[i])
			radicand_queue.push_back(directed[i]);
		for (int i = 0; i < 1100; i++)
			radicand_queue.push_back(random_radicand());

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: everything sent and every root back
		while (radicand_queue.size() > 0 || req_ch.valid || expected_roots.size() > 0)
			@(negedge clk);
		repeat (40) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

// File: integer_square_root.f
rtl/isr_pkg.sv
rtl/isr_if.sv
rtl/isr_cell.sv
rtl/integer_square_root.sv
tb/integer_square_root_test.sv
